@@ sv/lbre_pkg.sv @@
// ----------------------------------------------------------------------------
// lbre_pkg: shared types and constants of the letter buffer range engine
// Field widths, operation codes, defaults and the sequencer states.
// ----------------------------------------------------------------------------
package lbre_pkg;

	// fixed field widths
	localparam int LETTER_W = 5;
	localparam int POS_W    = 10;
	localparam int COUNT_W  = 11;
	localparam int OP_W     = 2;

	// parameter defaults
	localparam int BUFFER_DEPTH_DEF  = 1024;
	localparam int ALPHABET_SIZE_DEF = 26;

	// buffer length after reset
	localparam logic [COUNT_W-1:0] LENGTH_RESET = COUNT_W'(1024);

	// operation codes
	localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
	localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
	localparam logic [OP_W-1:0] OP_SORT  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_SCAN,
		ST_EMIT,
		ST_TAIL,
		ST_FINISH
	} state_t;

endpackage

@@ sv/lbre_ram.sv @@
// ----------------------------------------------------------------------------
// lbre_ram: generic single write port, single read port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module lbre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/letter_buffer_range_engine.sv @@
// ----------------------------------------------------------------------------
// letter_buffer_range_engine: count, fill and sort over a buffer of letters
// Range operations on a RAM of letter codes, run by a small sequencer.
// ----------------------------------------------------------------------------
// The buffer holds BUFFER_DEPTH letter codes (0 for a up to ALPHABET_SIZE-1)
// or the empty code ALPHABET_SIZE. After reset the engine sweeps the whole
// RAM to the empty code, one position a cycle, and takes no input beat until
// the sweep is done (config writes are taken meanwhile). Each input beat
// runs one operation on the inclusive range range_start..range_end and gives
// exactly one result beat. All work goes through the single RAM port pair,
// one position per cycle: a fill writes the range, a count reads it (the
// read data is registered in the RAM), and a sort makes a read pass to build
// the histogram, then a write pass, ordered by letter, with the empty codes
// written last. Rejected items (range error, start after end, unused
// operation) go straight to the finish step. in_stall is high while an item
// is at work; a finished result sits in the output register until the sink
// takes it, and a stalled sink holds the engine in its finish step only once
// a second result is ready.
// ----------------------------------------------------------------------------
module letter_buffer_range_engine
	import lbre_pkg::*;
#(
	parameter int BUFFER_DEPTH  = BUFFER_DEPTH_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,

	// configuration
	input  logic                cfg_we,
	input  logic [COUNT_W-1:0]  cfg_wdata,

	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic [POS_W-1:0]    range_start,
	input  logic [POS_W-1:0]    range_end,
	input  logic [LETTER_W-1:0] letter,

	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [COUNT_W-1:0]  letter_count,
	output logic                range_error
);

	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int HIST_W = $clog2(ALPHABET_SIZE);
	localparam logic [ADDR_W-1:0]   LAST_ADDR   = ADDR_W'(BUFFER_DEPTH - 1);
	localparam logic [LETTER_W-1:0] EMPTY_CODE  = LETTER_W'(ALPHABET_SIZE);
	localparam logic [HIST_W-1:0]   LAST_LETTER = HIST_W'(ALPHABET_SIZE - 1);

	state_t state_q, state_d;

	// configuration register
	logic [COUNT_W-1:0] buffer_length_q;

	// item registers
	logic [OP_W-1:0]     op_q;
	logic [POS_W-1:0]    lo_q;
	logic [POS_W-1:0]    hi_q;
	logic [LETTER_W-1:0] letter_q;
	logic [LETTER_W-1:0] fill_code_q;

	// walk state
	logic [POS_W:0]      pos_q;      // one extra bit, tail pass runs to hi+1
	logic [ADDR_W-1:0]   clr_q;
	logic                issued_q;
	logic                rd_vld_s1;
	logic [HIST_W-1:0]   c_q;
	logic [COUNT_W-1:0]  count_q;
	logic                err_q;
	logic [COUNT_W-1:0]  hist_q [ALPHABET_SIZE];

	// result register
	logic                out_valid_q;
	logic [COUNT_W-1:0]  letter_count_q;
	logic                range_error_q;

	// ram port
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [LETTER_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [LETTER_W-1:0] mem_rdata;

	// decode of the arriving item
	logic                accept;
	logic                op_known;
	logic                end_bad;
	logic                do_work;

	// histogram port, one address shared by the scan and emit passes
	logic [HIST_W-1:0]   hist_idx;
	logic [COUNT_W-1:0]  hist_cur;
	logic                scan_letter;
	logic                pos_at_hi;
	logic                pos_le_hi;
	logic                finish_go;

	assign accept   = in_valid && !in_stall;
	assign op_known = (operation == OP_COUNT) || (operation == OP_FILL) ||
		(operation == OP_SORT);
	// end at or past the length in use, length saturating at the depth
	assign end_bad  = ({1'b0, range_end} >= buffer_length_q) ||
		(32'(range_end) >= 32'(BUFFER_DEPTH));
	assign do_work  = op_known && !end_bad && (range_start <= range_end);

	assign scan_letter = (mem_rdata < EMPTY_CODE);
	assign hist_idx    = (state_q == ST_SCAN) ? HIST_W'(mem_rdata) : c_q;
	assign hist_cur    = hist_q[hist_idx];
	assign pos_at_hi   = (pos_q == {1'b0, hi_q});
	assign pos_le_hi   = (pos_q <= {1'b0, hi_q});
	assign finish_go   = !out_valid_q || !out_stall;

	lbre_ram #(
		.WIDTH (LETTER_W),
		.DEPTH (BUFFER_DEPTH),
		.AW    (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ram controls
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'(pos_q);
		mem_wdata = EMPTY_CODE;
		mem_raddr = ADDR_W'(pos_q);
		in_stall  = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				// sweep after reset
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (accept) begin
					if (!do_work) begin
						state_d = ST_FINISH;
					end else if (operation == OP_FILL) begin
						state_d = ST_FILL;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = fill_code_q;
				if (pos_at_hi) begin
					state_d = ST_FINISH;
				end
			end
			ST_SCAN: begin
				// leave once the last read has come back
				if (issued_q && !rd_vld_s1) begin
					state_d = (op_q == OP_SORT) ? ST_EMIT : ST_FINISH;
				end
			end
			ST_EMIT: begin
				if (hist_cur != '0) begin
					mem_we    = 1'b1;
					mem_wdata = LETTER_W'(c_q);
				end else if (c_q == LAST_LETTER) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				// empty positions at the end of the sorted range
				if (pos_le_hi) begin
					mem_we = 1'b1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (finish_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= LENGTH_RESET;
			clr_q           <= '0;
			issued_q        <= 1'b0;
			rd_vld_s1       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				buffer_length_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				issued_q <= 1'b0;
			end else if (state_q == ST_SCAN && !issued_q && pos_at_hi) begin
				issued_q <= 1'b1;
			end
			rd_vld_s1 <= (state_q == ST_SCAN) && !issued_q;
			if (state_q == ST_FINISH && finish_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= operation;
			lo_q        <= range_start;
			hi_q        <= range_end;
			letter_q    <= letter;
			fill_code_q <= (letter < EMPTY_CODE) ? letter : EMPTY_CODE;
			pos_q       <= {1'b0, range_start};
			count_q     <= '0;
			err_q       <= op_known && end_bad;
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				hist_q[i] <= '0;
			end
		end
		unique case (state_q)
			ST_FILL: begin
				pos_q <= pos_q + 1'b1;
			end
			ST_SCAN: begin
				if (!issued_q && !pos_at_hi) begin
					pos_q <= pos_q + 1'b1;
				end
				if (rd_vld_s1) begin
					if (op_q == OP_COUNT) begin
						if (mem_rdata == letter_q && letter_q < EMPTY_CODE) begin
							count_q <= count_q + 1'b1;
						end
					end else if (scan_letter) begin
						hist_q[hist_idx] <= hist_cur + 1'b1;
					end
				end
				if (issued_q && !rd_vld_s1) begin
					// rewind for the write pass
					pos_q <= {1'b0, lo_q};
					c_q   <= '0;
				end
			end
			ST_EMIT: begin
				if (hist_cur != '0) begin
					hist_q[hist_idx] <= hist_cur - 1'b1;
					pos_q            <= pos_q + 1'b1;
				end else if (c_q != LAST_LETTER) begin
					c_q <= c_q + 1'b1;
				end
			end
			ST_TAIL: begin
				if (pos_le_hi) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			ST_FINISH: begin
				if (finish_go) begin
					letter_count_q <= count_q;
					range_error_q  <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign letter_count = letter_count_q;
	assign range_error  = range_error_q;

endmodule

@@ sim/letter_buffer_range_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_buffer_range_engine_tb: self-checking bench for the letter buffer
// Drives count, fill and sort beats over directed corner cases and random
// ranges under several buffer lengths and idle/stall mixes. A local model of
// the buffer predicts every result beat, which is checked field by field.
// ----------------------------------------------------------------------------
module letter_buffer_range_engine_tb;
	import lbre_pkg::*;

	localparam int DEPTH      = BUFFER_DEPTH_DEF;
	localparam int ALPHABET   = ALPHABET_SIZE_DEF;
	localparam int WATCHDOG   = 20000;
	localparam int DRAIN_WAIT = 8;       // settle time after the last result beat

	// spare operation code, must be ignored by the engine
	localparam logic [OP_W-1:0]     OP_UNUSED  = 2'd3;
	localparam logic [LETTER_W-1:0] EMPTY_CODE = LETTER_W'(ALPHABET);

	typedef struct packed {
		logic [COUNT_W-1:0] count_val;
		logic               error_flag;
	} result_t;

	// clock, reset and block inputs, all known from time zero
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_we       = 1'b0;
	logic [COUNT_W-1:0]  cfg_wdata    = '0;
	logic                in_valid     = 1'b0;
	logic [OP_W-1:0]     operation    = OP_COUNT;
	logic [POS_W-1:0]    range_start  = '0;
	logic [POS_W-1:0]    range_end    = '0;
	logic [LETTER_W-1:0] letter       = '0;
	logic                out_stall    = 1'b0;
	logic                in_stall;
	logic                out_valid;
	logic [COUNT_W-1:0]  letter_count;
	logic                range_error;

	// shadow of the buffer and its length register
	logic [LETTER_W-1:0] letter_store_model [DEPTH];
	int unsigned         length_model;

	// predicted result beats, oldest first
	result_t             expected_results [$];
	result_t             oldest_expected;

	// idle/stall knobs, in percent per cycle
	int                  send_idle_pct = 0;
	int                  stall_pct     = 0;

	int                  failures      = 0;
	int                  results_seen  = 0;
	int                  error_beats   = 0;
	int                  beats_by_op [4];
	int                  quiet_cycles  = 0;

	always #5 clk = ~clk;

	letter_buffer_range_engine u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.range_start  (range_start),
		.range_end    (range_end),
		.letter       (letter),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.letter_count (letter_count),
		.range_error  (range_error)
	);

	// ------------------------------------------------------------------
	// buffer model: applies one operation and returns its result beat
	// ------------------------------------------------------------------
	function automatic result_t apply_operation(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
			input logic [LETTER_W-1:0] code);
		result_t     outcome;
		int unsigned in_use;
		int unsigned tally [ALPHABET];
		int unsigned p;
		int unsigned c;
		int unsigned k;
		int unsigned pos;
		outcome = '0;
		// length register saturates at the buffer depth
		in_use = (length_model > DEPTH) ? DEPTH : length_model;
		// the range check comes first and applies even when start > end;
		// the spare code skips it altogether
		if (op == OP_COUNT || op == OP_FILL || op == OP_SORT) begin
			if (hi >= in_use) begin
				outcome.error_flag = 1'b1;
			end else if (lo <= hi) begin
				case (op)
				OP_COUNT: begin
					// empty positions are never counted
					if (code < ALPHABET)
						for (p = lo; p <= hi; p++)
							if (letter_store_model[p] == code)
								outcome.count_val++;
				end
				OP_FILL: begin
					// a code outside the alphabet clears the range
					for (p = lo; p <= hi; p++)
						letter_store_model[p] = (code < ALPHABET) ? code : EMPTY_CODE;
				end
				OP_SORT: begin
					foreach (tally[i])
						tally[i] = 0;
					for (p = lo; p <= hi; p++)
						if (letter_store_model[p] < ALPHABET)
							tally[letter_store_model[p]]++;
					pos = lo;
					for (c = 0; c < ALPHABET; c++)
						for (k = 0; k < tally[c]; k++) begin
							letter_store_model[pos] = LETTER_W'(c);
							pos++;
						end
					// empties collect at the tail of the range
					for (; pos <= hi; pos++)
						letter_store_model[pos] = EMPTY_CODE;
				end
				default: ;
				endcase
			end
		end
		return outcome;
	endfunction

	// ------------------------------------------------------------------
	// sink side: random stall, compare each result beat with the oldest
	// expectation
	// ------------------------------------------------------------------
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result beat with no expectation waiting: letter_count %0d range_error %0d",
					letter_count, range_error);
				failures++;
			end else begin
				oldest_expected = expected_results.pop_front();
				if (letter_count !== oldest_expected.count_val) begin
					$error("letter_count: expected %0d, actual %0d",
						oldest_expected.count_val, letter_count);
					failures++;
				end
				if (range_error !== oldest_expected.error_flag) begin
					$error("range_error: expected %0d, actual %0d",
						oldest_expected.error_flag, range_error);
					failures++;
				end
			end
		end
	end

	// watchdog: cycles in which neither channel moves a beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("watchdog: no beat for %0d cycles, %0d results outstanding",
					WATCHDOG, expected_results.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// source side
	// ------------------------------------------------------------------

	// one input beat: optional random gap, then hold until accepted;
	// valid stays high into the next beat when there is no gap
	task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] lo,
			input logic [POS_W-1:0] hi, input logic [LETTER_W-1:0] code);
		result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		operation   <= op;
		range_start <= lo;
		range_end   <= hi;
		letter      <= code;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = apply_operation(op, lo, hi, code);
		expected_results.push_back(predicted);
		beats_by_op[op]++;
		if (predicted.error_flag)
			error_beats++;
	endtask

	// stop sending and wait until every predicted result beat has arrived
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// length register is only written with the engine idle
	task automatic set_buffer_length(input int unsigned value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= COUNT_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		length_model = value;
	endtask

	// random beats, mostly short well-formed ranges over a small letter set
	// so counts come out nonzero; a few full-depth ranges, bad ranges and
	// spare opcodes mixed in
	task automatic random_burst(input int beats);
		int unsigned      in_use;
		int unsigned      span;
		int unsigned      lo;
		int unsigned      hi;
		int unsigned      pick;
		logic [OP_W-1:0]  op;
		logic [LETTER_W-1:0] code;
		in_use = (length_model > DEPTH) ? DEPTH : length_model;
		for (int n = 0; n < beats; n++) begin
			pick = $urandom_range(99);
			op   = (pick < 35) ? OP_COUNT : (pick < 70) ? OP_FILL :
			       (pick < 95) ? OP_SORT : OP_UNUSED;
			pick = $urandom_range(99);
			span = (pick < 80) ? $urandom_range(15) :
			       (pick < 97) ? $urandom_range(120) : $urandom_range(DEPTH - 1);
			lo   = $urandom_range(in_use - 1);
			hi   = (lo + span > in_use - 1) ? in_use - 1 : lo + span;
			pick = $urandom_range(99);
			if (pick < 5) begin
				// end beyond the length in use, or start after end at full depth
				if (in_use < DEPTH)
					hi = $urandom_range(DEPTH - 1, in_use);
				else if (lo != hi)
					{lo, hi} = {hi, lo};
			end else if (pick < 10 && lo != hi) begin
				{lo, hi} = {hi, lo};
			end
			pick = $urandom_range(99);
			code = (pick < 50) ? LETTER_W'($urandom_range(3)) :
			       (pick < 92) ? LETTER_W'($urandom_range(ALPHABET - 1)) :
			       LETTER_W'($urandom_range((1 << LETTER_W) - 1, ALPHABET));
			send_item(op, POS_W'(lo), POS_W'(hi), code);
			// now and then let the pipe run dry before the next beat
			if ($urandom_range(99) < 3)
				wait_drained();
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// fresh buffer holds only empties, so nothing counts and sort is a no-op
	task automatic test_empty_buffer();
		send_item(OP_COUNT, '0, '1, LETTER_W'(0));
		send_item(OP_COUNT, '0, '1, '1);
		send_item(OP_SORT, '0, '1, '0);
		send_item(OP_COUNT, '1, '1, LETTER_W'(ALPHABET - 1));
	endtask

	// extremes of range and letter, full-depth fill and sort, maximum count
	task automatic test_fill_and_sort();
		send_item(OP_FILL, '0, '1, LETTER_W'(ALPHABET - 1));
		send_item(OP_COUNT, '0, '1, LETTER_W'(ALPHABET - 1));
		send_item(OP_FILL, '0, '0, LETTER_W'(0));
		send_item(OP_FILL, '1, '1, '1);                 // clears the last position
		send_item(OP_COUNT, '0, '1, EMPTY_CODE);        // empty code is never counted
		send_item(OP_FILL, POS_W'(512), POS_W'(519), LETTER_W'(3));
		send_item(OP_SORT, '0, '1, '0);
		send_item(OP_COUNT, POS_W'(1), POS_W'(8), LETTER_W'(3));
		send_item(OP_COUNT, '0, '1, LETTER_W'(ALPHABET - 1));
	endtask

	// start after end for every operation, and the spare opcode
	task automatic test_start_after_end();
		send_item(OP_COUNT, POS_W'(700), POS_W'(5), LETTER_W'(ALPHABET - 1));
		send_item(OP_FILL, '1, '0, LETTER_W'(7));
		send_item(OP_SORT, POS_W'(6), POS_W'(5), '0);
		send_item(OP_UNUSED, '1, '1, '1);
	endtask

	// zero, one, saturating and default lengths; range check beats start > end
	task automatic test_length_limits();
		set_buffer_length(0);
		send_item(OP_COUNT, '0, '0, LETTER_W'(1));
		send_item(OP_FILL, '0, '0, LETTER_W'(1));
		send_item(OP_SORT, '0, '0, '0);
		send_item(OP_UNUSED, '0, '0, '0);
		set_buffer_length(1);
		send_item(OP_COUNT, '0, '0, LETTER_W'(0));
		send_item(OP_FILL, POS_W'(1), POS_W'(1), LETTER_W'(2));
		send_item(OP_COUNT, POS_W'(5), POS_W'(1), LETTER_W'(0));
		set_buffer_length((1 << COUNT_W) - 1);
		send_item(OP_FILL, POS_W'(1020), '1, LETTER_W'(7));
		send_item(OP_COUNT, POS_W'(1016), '1, LETTER_W'(7));
		set_buffer_length(DEPTH);
	endtask

	task automatic test_random_no_idle();
		send_idle_pct = 0;
		stall_pct     = 0;
		set_buffer_length(DEPTH);
		random_burst(68);
	endtask

	task automatic test_random_sender_gaps();
		send_idle_pct = 67;
		stall_pct     = 0;
		set_buffer_length(300);
		random_burst(68);
	endtask

	task automatic test_random_receiver_stalls();
		send_idle_pct = 0;
		stall_pct     = 67;
		set_buffer_length((1 << COUNT_W) - 1);
		random_burst(68);
	endtask

	task automatic test_random_both_idle();
		send_idle_pct = 20;
		stall_pct     = 20;
		set_buffer_length(37);
		random_burst(68);
	endtask

	initial begin
		foreach (letter_store_model[i])
			letter_store_model[i] = EMPTY_CODE;
		foreach (beats_by_op[i])
			beats_by_op[i] = 0;
		length_model = LENGTH_RESET;

		// reset once; the engine then clears its RAM before taking beats
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_buffer();
		test_fill_and_sort();
		test_start_after_end();
		test_length_limits();
		test_random_no_idle();
		test_random_sender_gaps();
		test_random_receiver_stalls();
		test_random_both_idle();

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected result beats never arrived", expected_results.size());
			failures++;
		end

		$display("covered %0d count, %0d fill, %0d sort, %0d spare-opcode beats, %0d range errors",
			beats_by_op[OP_COUNT], beats_by_op[OP_FILL], beats_by_op[OP_SORT],
			beats_by_op[OP_UNUSED], error_beats);
		$display("lengths 0, 1, 37, 300, 1024, 2047 under four idle/stall mixes, %0d results checked",
			results_seen);
		if (failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ letter_buffer_range_engine.f @@
sv/lbre_pkg.sv
sv/lbre_ram.sv
sv/letter_buffer_range_engine.sv
sim/letter_buffer_range_engine_tb.sv
